>>> hw/rtl/movdec_pkg.sv
// ----------------------------------------------------------------------------
// movdec_pkg
// Shared types, form codes and opcode family tests for the MOV byte decoder.
// ----------------------------------------------------------------------------
package movdec_pkg;

	localparam logic [2:0] FORM_REG_REG = 3'd0;
	localparam logic [2:0] FORM_MEM_REG = 3'd1;
	localparam logic [2:0] FORM_IMM_REG = 3'd2;
	localparam logic [2:0] FORM_IMM_MEM = 3'd3;
	localparam logic [2:0] FORM_ACC_DIR = 3'd4;
	localparam logic [2:0] FORM_INVALID = 3'd5;

	localparam logic [1:0] MOD_NO_DISP = 2'd0;
	localparam logic [1:0] MOD_DISP8   = 2'd1;
	localparam logic [1:0] MOD_DISP16  = 2'd2;
	localparam logic [1:0] MOD_REG     = 2'd3;

	localparam logic [2:0] RM_DIRECT = 3'd6;

	// Instruction contents as collected so far, with a flag for completion.
	typedef struct packed {
		logic        done;
		logic [7:0]  opcode;
		logic [7:0]  modrm;
		logic [15:0] disp;
		logic [15:0] imm;
	} movdec_insn_t;

	typedef struct packed {
		logic [2:0]  form;
		logic        to_register;
		logic        wide;
		logic [2:0]  reg_code;
		logic [2:0]  rm_code;
		logic [1:0]  mode;
		logic        direct;
		logic [15:0] displacement;
		logic [15:0] direct_address;
		logic [15:0] immediate;
	} movdec_result_t;

	function automatic logic is_regrm(input logic [7:0] op);
		return (op & 8'hFC) == 8'h88;
	endfunction

	function automatic logic is_immreg(input logic [7:0] op);
		return (op & 8'hF0) == 8'hB0;
	endfunction

	function automatic logic is_immrm(input logic [7:0] op);
		return (op & 8'hFE) == 8'hC6;
	endfunction

	function automatic logic is_accum(input logic [7:0] op);
		return (op & 8'hFC) == 8'hA0;
	endfunction

	// Number of displacement or direct address bytes implied by a mod-reg-rm byte.
	function automatic logic [2:0] disp_bytes(input logic [7:0] modrm);
		logic [2:0] n;
		case (modrm[7:6])
			MOD_NO_DISP: n = (modrm[2:0] == RM_DIRECT) ? 3'd2 : 3'd0;
			MOD_DISP8:   n = 3'd1;
			MOD_DISP16:  n = 3'd2;
			default:     n = 3'd0;
		endcase
		return n;
	endfunction

endpackage

>>> hw/rtl/movdec_collect.sv
// ----------------------------------------------------------------------------
// movdec_collect
// Byte position tracking and collection of opcode, mod-reg-rm, displacement
// and immediate bytes. Presents the instruction as it stands after the
// current byte, flagged done when that byte completes it.
// ----------------------------------------------------------------------------
module movdec_collect import movdec_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         take,
	input  logic [7:0]   code_byte,
	output movdec_insn_t insn
);

	logic [2:0]  pos_q, pos_d;
	logic [2:0]  need_q, need_d;
	logic [7:0]  op_q, op_d;
	logic [7:0]  modrm_q, modrm_d;
	logic [15:0] disp_q, disp_d;
	logic [15:0] imm_q, imm_d;
	logic        done;
	logic [2:0]  k;
	logic [2:0]  nd;
	logic [2:0]  j_full;

	assign k      = pos_q - 3'd2;
	assign nd     = disp_bytes(modrm_q);
	assign j_full = k - nd;

	always_comb begin
		pos_d   = pos_q;
		need_d  = need_q;
		op_d    = op_q;
		modrm_d = modrm_q;
		disp_d  = disp_q;
		imm_d   = imm_q;
		done    = 1'b0;
		if (pos_q == 3'd0) begin
			op_d    = code_byte;
			modrm_d = '0;
			disp_d  = '0;
			imm_d   = '0;
			need_d  = '0;
			pos_d   = 3'd1;
		end else if (pos_q == 3'd1) begin
			if (is_regrm(op_q) || is_immrm(op_q) || is_immreg(op_q) || is_accum(op_q)) begin
				if (is_regrm(op_q)) begin
					modrm_d = code_byte;
					need_d  = disp_bytes(code_byte);
				end else if (is_immreg(op_q)) begin
					imm_d  = {8'h00, code_byte};
					need_d = op_q[3] ? 3'd1 : 3'd0;
				end else if (is_immrm(op_q)) begin
					modrm_d = code_byte;
					need_d  = disp_bytes(code_byte) + (op_q[0] ? 3'd2 : 3'd1);
				end else begin
					disp_d = {8'h00, code_byte};
					need_d = 3'd1;
				end
				if (need_d == 3'd0) begin
					done  = 1'b1;
					pos_d = 3'd0;
				end else begin
					pos_d = 3'd2;
				end
			end else begin
				// Unknown opcode: its second byte is swallowed without a result.
				pos_d = 3'd0;
			end
		end else begin
			if (is_immreg(op_q)) begin
				imm_d = imm_q | {code_byte, 8'h00};
			end else if (is_accum(op_q)) begin
				disp_d = disp_q | {code_byte, 8'h00};
			end else if (k < nd) begin
				disp_d = disp_q | (k[0] ? {code_byte, 8'h00} : {8'h00, code_byte});
			end else begin
				imm_d = imm_q | (j_full[0] ? {code_byte, 8'h00} : {8'h00, code_byte});
			end
			if (need_q != 3'd0) begin
				need_d = need_q - 3'd1;
			end
			if (need_d == 3'd0) begin
				done  = 1'b1;
				pos_d = 3'd0;
			end else begin
				pos_d = pos_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			need_q <= '0;
		end else if (take) begin
			pos_q  <= pos_d;
			need_q <= need_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q    <= op_d;
			modrm_q <= modrm_d;
			disp_q  <= disp_d;
			imm_q   <= imm_d;
		end
	end

	assign insn.done   = done;
	assign insn.opcode = op_d;
	assign insn.modrm  = modrm_d;
	assign insn.disp   = disp_d;
	assign insn.imm    = imm_d;

endmodule

>>> hw/rtl/movdec_format.sv
// ----------------------------------------------------------------------------
// movdec_format
// Turns a completed instruction into its decoded result fields.
// ----------------------------------------------------------------------------
module movdec_format import movdec_pkg::*; (
	input  movdec_insn_t   insn,
	output movdec_result_t res
);

	logic [1:0] md;
	logic [2:0] rg;
	logic [2:0] rm;

	assign md = insn.modrm[7:6];
	assign rg = insn.modrm[5:3];
	assign rm = insn.modrm[2:0];

	always_comb begin
		res = '0;
		if (is_regrm(insn.opcode) || is_immrm(insn.opcode)) begin
			res.wide     = insn.opcode[0];
			res.reg_code = rg;
			res.rm_code  = rm;
			res.mode     = md;
			if (md == MOD_NO_DISP && rm == RM_DIRECT) begin
				res.direct         = 1'b1;
				res.direct_address = insn.disp;
			end else if (md == MOD_DISP8) begin
				res.displacement = {{8{insn.disp[7]}}, insn.disp[7:0]};
			end else if (md == MOD_DISP16) begin
				res.displacement = insn.disp;
			end
			if (is_regrm(insn.opcode)) begin
				res.form        = (md == MOD_REG) ? FORM_REG_REG : FORM_MEM_REG;
				res.to_register = insn.opcode[1];
			end else begin
				res.immediate = insn.imm;
				if (rg != 3'd0) begin
					res.form        = FORM_INVALID;
					res.to_register = (md == MOD_REG);
				end else if (md == MOD_REG) begin
					// Register target through the r/m field: both codes name it.
					res.form        = FORM_IMM_REG;
					res.to_register = 1'b1;
					res.reg_code    = rm;
				end else begin
					res.form = FORM_IMM_MEM;
				end
			end
		end else if (is_immreg(insn.opcode)) begin
			res.form        = FORM_IMM_REG;
			res.to_register = 1'b1;
			res.wide        = insn.opcode[3];
			res.reg_code    = insn.opcode[2:0];
			res.immediate   = insn.imm;
		end else begin
			res.form           = FORM_ACC_DIR;
			res.to_register    = ~insn.opcode[1];
			res.wide           = insn.opcode[0];
			res.direct         = 1'b1;
			res.direct_address = insn.disp;
		end
	end

endmodule

>>> hw/rtl/mov_instruction_byte_decoder.sv
// ----------------------------------------------------------------------------
// mov_instruction_byte_decoder
// Byte-serial decoder for the register, immediate and accumulator MOV forms.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, code_byte) takes the code stream one
// byte per item, multi-byte values low byte first. The output channel
// (out_valid, out_ready and the decoded fields) delivers one item for each
// completed instruction, when its last byte is taken.
// A byte is taken in any cycle in which the output register is empty or is
// being emptied, so the block sustains one byte per cycle while the receiver
// does not stall. The result of a completing byte appears on the output in the
// cycle after that byte is taken. Instructions span two to six bytes; an
// unknown opcode consumes two bytes and yields no item.
// While the receiver stalls, the held result stays in place and in_ready is
// low, so no byte is lost. Reset empties the output register and returns the
// decoder to expecting an opcode.
// ----------------------------------------------------------------------------
module mov_instruction_byte_decoder import movdec_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         code_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         form,
	output logic               to_register,
	output logic               wide,
	output logic [2:0]         reg_code,
	output logic [2:0]         rm_code,
	output logic [1:0]         mode,
	output logic               direct,
	output logic signed [15:0] displacement,
	output logic [15:0]        direct_address,
	output logic [15:0]        immediate
);

	logic           take;
	logic           valid_q;
	movdec_insn_t   insn;
	movdec_result_t res;
	movdec_result_t res_q;

	assign in_ready = !valid_q || out_ready;
	assign take     = in_valid && in_ready;

	movdec_collect u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.code_byte (code_byte),
		.insn      (insn)
	);

	movdec_format u_format (
		.insn (insn),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= take && insn.done;
		end
	end

	always_ff @(posedge clk) begin
		if (take && insn.done) begin
			res_q <= res;
		end
	end

	assign out_valid      = valid_q;
	assign form           = res_q.form;
	assign to_register    = res_q.to_register;
	assign wide           = res_q.wide;
	assign reg_code       = res_q.reg_code;
	assign rm_code        = res_q.rm_code;
	assign mode           = res_q.mode;
	assign direct         = res_q.direct;
	assign displacement   = res_q.displacement;
	assign direct_address = res_q.direct_address;
	assign immediate      = res_q.immediate;

`ifndef SYNTHESIS
	a_rise_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result item appeared without a byte being taken");

	a_direct_no_disp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && direct |-> displacement == 16'sd0)
		else $error("direct operand carries a displacement");

	a_narrow_imm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wide |-> immediate[15:8] == 8'h00)
		else $error("8-bit immediate has a nonzero high byte");

	a_accum_direct: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && form == FORM_ACC_DIR |-> direct && reg_code == 3'd0)
		else $error("accumulator form decoded without a direct address");
`endif

endmodule
